/* sv/snpo_pkg.sv */
// ----------------------------------------------------------------------------
// snpo_pkg: shared types and constants of the segment nearest point block
// Beat payloads, clamp codes and default configuration.
// ----------------------------------------------------------------------------
package snpo_pkg;

  localparam int COORD_W       = 32;
  localparam int CFG_W         = 24;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] EDGE_WIDTH_RESET = 24'd65536;

  localparam logic [1:0] CLAMP_START = 2'd0;
  localparam logic [1:0] CLAMP_END   = 2'd1;
  localparam logic [1:0] CLAMP_FOOT  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic [1:0]                clamp_case;
    logic                      zero_distance;
  } result_t;

endpackage

/* sv/snpo_div.sv */
// ----------------------------------------------------------------------------
// snpo_div: pipelined restoring divider, two numerators over one divisor
// One quotient bit per stage; the quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module snpo_div #(
  parameter int N_W   = 98,
  parameter int D_W   = 66,
  parameter int Q_W   = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  logic [N_W-1:0]   num_a,
  input  logic [N_W-1:0]   num_b,
  input  logic [D_W-1:0]   divisor,
  input  logic [TAG_W-1:0] src_tag,
  output logic             dst_valid,
  input  logic             dst_ready,
  output logic [Q_W-1:0]   quo_a,
  output logic [Q_W-1:0]   quo_b,
  output logic [TAG_W-1:0] dst_tag
);

  localparam int R_W = D_W + Q_W;

  logic             v     [1:Q_W];
  logic             rdy   [1:Q_W+1];
  logic [R_W-1:0]   rem_a [1:Q_W];
  logic [R_W-1:0]   rem_b [1:Q_W];
  logic [Q_W-1:0]   qa    [1:Q_W];
  logic [Q_W-1:0]   qb    [1:Q_W];
  logic [D_W-1:0]   den   [1:Q_W];
  logic [TAG_W-1:0] tag   [1:Q_W];

  assign rdy[Q_W+1] = dst_ready;
  assign src_ready  = rdy[1];

  for (genvar j = 1; j <= Q_W; j++) begin : g_stage
    localparam int B = Q_W - j;
    logic [R_W-1:0]   pr_a, pr_b, dsh;
    logic [Q_W-1:0]   pq_a, pq_b;
    logic [D_W-1:0]   pd;
    logic [TAG_W-1:0] pt;
    logic             pv;

    if (j == 1) begin : g_head
      assign pv   = src_valid;
      assign pr_a = R_W'(num_a);
      assign pr_b = R_W'(num_b);
      assign pq_a = '0;
      assign pq_b = '0;
      assign pd   = divisor;
      assign pt   = src_tag;
    end else begin : g_tail
      assign pv   = v[j-1];
      assign pr_a = rem_a[j-1];
      assign pr_b = rem_b[j-1];
      assign pq_a = qa[j-1];
      assign pq_b = qb[j-1];
      assign pd   = den[j-1];
      assign pt   = tag[j-1];
    end

    assign dsh    = R_W'(pd) << B;
    assign rdy[j] = !v[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        den[j] <= pd;
        tag[j] <= pt;
        if (pr_a >= dsh) begin
          rem_a[j] <= pr_a - dsh;
          qa[j]    <= pq_a | (Q_W'(1) << B);
        end else begin
          rem_a[j] <= pr_a;
          qa[j]    <= pq_a;
        end
        if (pr_b >= dsh) begin
          rem_b[j] <= pr_b - dsh;
          qb[j]    <= pq_b | (Q_W'(1) << B);
        end else begin
          rem_b[j] <= pr_b;
          qb[j]    <= pq_b;
        end
      end
    end
  end

  assign dst_valid = v[Q_W];
  assign quo_a     = qa[Q_W];
  assign quo_b     = qb[Q_W];
  assign dst_tag   = tag[Q_W];

endmodule

/* sv/snpo_sqrt.sv */
// ----------------------------------------------------------------------------
// snpo_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per stage, floor of the root.
// ----------------------------------------------------------------------------
module snpo_sqrt #(
  parameter int R_W   = 33,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  logic [2*R_W-1:0] radicand,
  input  logic [TAG_W-1:0] src_tag,
  output logic             dst_valid,
  input  logic             dst_ready,
  output logic [R_W-1:0]   root,
  output logic [TAG_W-1:0] dst_tag
);

  localparam int S_W = 2 * R_W;

  logic             v   [1:R_W];
  logic             rdy [1:R_W+1];
  logic [S_W-1:0]   rem [1:R_W];
  logic [R_W-1:0]   rt  [1:R_W];
  logic [TAG_W-1:0] tag [1:R_W];

  assign rdy[R_W+1] = dst_ready;
  assign src_ready  = rdy[1];

  for (genvar j = 1; j <= R_W; j++) begin : g_stage
    localparam int B = R_W - j;
    logic [S_W-1:0]   pr, trial;
    logic [R_W-1:0]   prt;
    logic [TAG_W-1:0] pt;
    logic             pv;

    if (j == 1) begin : g_head
      assign pv  = src_valid;
      assign pr  = radicand;
      assign prt = '0;
      assign pt  = src_tag;
    end else begin : g_tail
      assign pv  = v[j-1];
      assign pr  = rem[j-1];
      assign prt = rt[j-1];
      assign pt  = tag[j-1];
    end

    // Growth of the square when this root bit is set: 2^B * (2*root + 2^B).
    assign trial  = (S_W'(prt) << (B + 1)) | (S_W'(1) << (2 * B));
    assign rdy[j] = !v[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        tag[j] <= pt;
        if (pr >= trial) begin
          rem[j] <= pr - trial;
          rt[j]  <= prt | (R_W'(1) << B);
        end else begin
          rem[j] <= pr;
          rt[j]  <= prt;
        end
      end
    end
  end

  assign dst_valid = v[R_W];
  assign root      = rt[R_W];
  assign dst_tag   = tag[R_W];

endmodule

/* sv/segment_nearest_point_offset_core.sv */
// ----------------------------------------------------------------------------
// segment_nearest_point_offset_core: nearest point on a segment, pushed out
// Clamps the query's projection to the segment and offsets the point.
// ----------------------------------------------------------------------------
// One query beat is taken every clock unless query_stall is raised, and one
// result beat leaves per query, in order. With W2 = 48 - FRAC_BITS, the
// projection divider spends one stage per quotient bit (32), the square root
// one stage per root bit (33) and the push divider one stage per bit of the
// squared width (W2). Every stage has its own valid bit and moves when the
// stage after it is empty or moving, so bubbles close up and queries keep
// entering while a result waits at the output, until the pipeline is full.
// A write on the width port is taken every cycle; each query picks up the
// registered squared width as it leaves the square root.
module segment_nearest_point_offset_core #(
  parameter int FRAC_BITS = snpo_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      query_valid,
  output logic                      query_stall,
  input  snpo_pkg::query_t          query,
  output logic                      result_valid,
  input  logic                      result_stall,
  output snpo_pkg::result_t         result,
  input  logic                      width_valid,
  output logic                      width_ready,
  input  logic [snpo_pkg::CFG_W-1:0] width_data
);
  import snpo_pkg::*;

  localparam int W2_W  = 2 * CFG_W - FRAC_BITS;
  localparam int W2L   = W2_W / 2;
  localparam int W2H   = W2_W - W2L;
  localparam int PL_W  = 32 + W2L;
  localparam int PH_W  = 32 + W2H;
  localparam int N2_W  = 32 + W2_W;
  localparam int RS_W  = ((W2_W > 32) ? W2_W : 32) + 2;

  typedef struct packed {
    logic signed [31:0] sx, sy, ex, ey, qx, qy;
    logic signed [32:0] dx, dy, a0, a1, b0, b1;
  } sa_t;

  typedef struct packed {
    logic signed [31:0] sx, sy, ex, ey, qx, qy;
    logic signed [32:0] dx, dy;
    logic signed [65:0] p0, p1, p2, p3, p4, p5;
  } sb_t;

  typedef struct packed {
    logic signed [31:0] sx, sy, ex, ey, qx, qy;
    logic signed [32:0] dx, dy;
    logic signed [66:0] dot1;
    logic               dot2_neg;
    logic [65:0]        len2;
  } sc_t;

  typedef struct packed {
    logic signed [31:0] base_x, base_y, qx, qy;
    logic               neg_x, neg_y;
    logic [1:0]         kind;
  } t1_t;

  typedef struct packed {
    t1_t         t1;
    logic [65:0] len2;
    logic [64:0] plx, phx, ply, phy;
  } sd_t;

  typedef struct packed {
    t1_t         t1;
    logic [65:0] len2;
    logic [97:0] numx, numy;
  } se_t;

  typedef struct packed {
    logic signed [31:0] fx, fy, qx, qy;
    logic [1:0]         kind;
  } sf_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic signed [32:0] vx, vy;
    logic [1:0]         kind;
    logic               zero;
  } sg_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic [31:0]        avx, avy;
    logic               neg_x, neg_y;
    logic [1:0]         kind;
    logic               zero;
  } t2_t;

  typedef struct packed {
    t2_t         t2;
    logic [63:0] sqx, sqy;
  } sh_t;

  typedef struct packed {
    t2_t         t2;
    logic [64:0] s;
  } si_t;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic               neg_x, neg_y;
    logic [1:0]         kind;
    logic               zero;
  } t3_t;

  typedef struct packed {
    t3_t             t3;
    logic [32:0]     vlen;
    logic [PL_W-1:0] plx, ply;
    logic [PH_W-1:0] phx, phy;
  } sj_t;

  typedef struct packed {
    t3_t             t3;
    logic [32:0]     vlen;
    logic [N2_W-1:0] n2x, n2y;
  } sk_t;

  function automatic logic signed [32:0] ext33(input logic signed [31:0] x);
    ext33 = {x[31], x};
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic signed [32:0] n;
    n = -x;
    mag33 = x[32] ? n[31:0] : x[31:0];
  endfunction

  function automatic logic [31:0] sat(input logic signed [RS_W-1:0] x);
    if (&x[RS_W-1:31] || ~|x[RS_W-1:31]) begin
      sat = x[31:0];
    end else if (x[RS_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7fff_ffff;
    end
  endfunction

  // Configuration.
  logic [CFG_W-1:0] edge_width;
  logic [W2_W-1:0]  w2;
  logic [2*CFG_W-1:0] wsq;

  assign width_ready = 1'b1;
  assign wsq = (2*CFG_W)'(edge_width) * (2*CFG_W)'(edge_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_width <= EDGE_WIDTH_RESET;
    end else if (width_valid) begin
      edge_width <= width_data;
    end
  end

  always_ff @(posedge clk) begin
    w2 <= W2_W'(wsq >> FRAC_BITS);
  end

  // Stage registers and their valid bits.
  sa_t a, a_next;
  sb_t b, b_next;
  sc_t c, c_next;
  sd_t d, d_next;
  se_t e, e_next;
  sf_t f, f_next;
  sg_t g, g_next;
  sh_t h, h_next;
  si_t i, i_next;
  sj_t j, j_next;
  sk_t k, k_next;
  result_t l_next;
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v, i_v, j_v, k_v, l_v;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h, rdy_i, rdy_j,
        rdy_k, rdy_l;

  // Projection divider, square root and push divider links.
  logic        d1_src_ready, d1_dst_valid;
  logic [31:0] tx, ty;
  logic [$bits(t1_t)-1:0] d1_tag;
  t1_t         d1_t1;
  logic        sq_src_ready, sq_dst_valid;
  logic [32:0] vlen;
  logic [$bits(t2_t)-1:0] sq_tag;
  t2_t         sq_t2;
  logic        d2_src_ready, d2_dst_valid;
  logic [W2_W-1:0] ox, oy;
  logic [$bits(t3_t)-1:0] d2_tag;
  t3_t         d2_t3;

  assign d1_t1 = d1_tag;
  assign sq_t2 = sq_tag;
  assign d2_t3 = d2_tag;

  assign rdy_l = !l_v || !result_stall;
  assign rdy_k = !k_v || d2_src_ready;
  assign rdy_j = !j_v || rdy_k;
  assign rdy_i = !i_v || sq_src_ready;
  assign rdy_h = !h_v || rdy_i;
  assign rdy_g = !g_v || rdy_h;
  assign rdy_f = !f_v || rdy_g;
  assign rdy_e = !e_v || d1_src_ready;
  assign rdy_d = !d_v || rdy_e;
  assign rdy_c = !c_v || rdy_d;
  assign rdy_b = !b_v || rdy_c;
  assign rdy_a = !a_v || rdy_b;
  assign query_stall  = !rdy_a;
  assign result_valid = l_v;

  // Differences.
  always_comb begin
    a_next.sx = query.seg_start_x;
    a_next.sy = query.seg_start_y;
    a_next.ex = query.seg_end_x;
    a_next.ey = query.seg_end_y;
    a_next.qx = query.query_x;
    a_next.qy = query.query_y;
    a_next.dx = ext33(query.seg_end_x) - ext33(query.seg_start_x);
    a_next.dy = ext33(query.seg_end_y) - ext33(query.seg_start_y);
    a_next.a0 = ext33(query.query_x) - ext33(query.seg_start_x);
    a_next.a1 = ext33(query.query_y) - ext33(query.seg_start_y);
    a_next.b0 = ext33(query.query_x) - ext33(query.seg_end_x);
    a_next.b1 = ext33(query.query_y) - ext33(query.seg_end_y);
  end

  // Products for both projection tests and the squared length.
  always_comb begin
    b_next.sx = a.sx;
    b_next.sy = a.sy;
    b_next.ex = a.ex;
    b_next.ey = a.ey;
    b_next.qx = a.qx;
    b_next.qy = a.qy;
    b_next.dx = a.dx;
    b_next.dy = a.dy;
    b_next.p0 = 66'(a.dx) * 66'(a.a0);
    b_next.p1 = 66'(a.dy) * 66'(a.a1);
    b_next.p2 = 66'(a.dx) * 66'(a.b0);
    b_next.p3 = 66'(a.dy) * 66'(a.b1);
    b_next.p4 = 66'(a.dx) * 66'(a.dx);
    b_next.p5 = 66'(a.dy) * 66'(a.dy);
  end

  always_comb begin
    logic signed [66:0] dot2;
    c_next.sx   = b.sx;
    c_next.sy   = b.sy;
    c_next.ex   = b.ex;
    c_next.ey   = b.ey;
    c_next.qx   = b.qx;
    c_next.qy   = b.qy;
    c_next.dx   = b.dx;
    c_next.dy   = b.dy;
    c_next.dot1 = 67'(b.p0) + 67'(b.p1);
    dot2        = 67'(b.p2) + 67'(b.p3);
    c_next.dot2_neg = dot2[66];
    c_next.len2 = $unsigned(b.p4) + $unsigned(b.p5);
  end

  // Clamp decision and the first half of the foot numerators.
  always_comb begin
    logic [31:0] adx, ady;
    adx = mag33(c.dx);
    ady = mag33(c.dy);
    if (c.dot1[66] || c.dot1 == '0) begin
      d_next.t1.kind = CLAMP_START;
    end else if (!c.dot2_neg) begin
      d_next.t1.kind = CLAMP_END;
    end else begin
      d_next.t1.kind = CLAMP_FOOT;
    end
    d_next.t1.base_x = (d_next.t1.kind == CLAMP_END) ? c.ex : c.sx;
    d_next.t1.base_y = (d_next.t1.kind == CLAMP_END) ? c.ey : c.sy;
    d_next.t1.qx     = c.qx;
    d_next.t1.qy     = c.qy;
    d_next.t1.neg_x  = c.dx[32];
    d_next.t1.neg_y  = c.dy[32];
    d_next.len2      = c.len2;
    d_next.plx = 65'(c.dot1[32:0]) * 65'(adx);
    d_next.phx = 65'(c.dot1[65:33]) * 65'(adx);
    d_next.ply = 65'(c.dot1[32:0]) * 65'(ady);
    d_next.phy = 65'(c.dot1[65:33]) * 65'(ady);
  end

  always_comb begin
    e_next.t1   = d.t1;
    e_next.len2 = d.len2;
    e_next.numx = (98'(d.phx) << 33) + 98'(d.plx);
    e_next.numy = (98'(d.phy) << 33) + 98'(d.ply);
  end

  snpo_div #(
    .N_W  (98),
    .D_W  (66),
    .Q_W  (32),
    .TAG_W($bits(t1_t))
  ) u_div_foot (
    .clk      (clk),
    .rst      (rst),
    .src_valid(e_v),
    .src_ready(d1_src_ready),
    .num_a    (e.numx),
    .num_b    (e.numy),
    .divisor  (e.len2),
    .src_tag  (e.t1),
    .dst_valid(d1_dst_valid),
    .dst_ready(rdy_f),
    .quo_a    (tx),
    .quo_b    (ty),
    .dst_tag  (d1_tag)
  );

  // The foot lies between the endpoints, so it always fits the coordinate width.
  always_comb begin
    logic signed [33:0] fx34, fy34;
    fx34 = d1_t1.neg_x ? 34'(d1_t1.base_x) - $signed({2'b00, tx})
                       : 34'(d1_t1.base_x) + $signed({2'b00, tx});
    fy34 = d1_t1.neg_y ? 34'(d1_t1.base_y) - $signed({2'b00, ty})
                       : 34'(d1_t1.base_y) + $signed({2'b00, ty});
    f_next.fx   = (d1_t1.kind == CLAMP_FOOT) ? fx34[31:0] : d1_t1.base_x;
    f_next.fy   = (d1_t1.kind == CLAMP_FOOT) ? fy34[31:0] : d1_t1.base_y;
    f_next.qx   = d1_t1.qx;
    f_next.qy   = d1_t1.qy;
    f_next.kind = d1_t1.kind;
  end

  always_comb begin
    g_next.fx   = f.fx;
    g_next.fy   = f.fy;
    g_next.vx   = ext33(f.fx) - ext33(f.qx);
    g_next.vy   = ext33(f.fy) - ext33(f.qy);
    g_next.kind = f.kind;
    g_next.zero = (g_next.vx == '0) && (g_next.vy == '0);
  end

  always_comb begin
    h_next.t2.fx    = g.fx;
    h_next.t2.fy    = g.fy;
    h_next.t2.avx   = mag33(g.vx);
    h_next.t2.avy   = mag33(g.vy);
    h_next.t2.neg_x = g.vx[32];
    h_next.t2.neg_y = g.vy[32];
    h_next.t2.kind  = g.kind;
    h_next.t2.zero  = g.zero;
    h_next.sqx = 64'(h_next.t2.avx) * 64'(h_next.t2.avx);
    h_next.sqy = 64'(h_next.t2.avy) * 64'(h_next.t2.avy);
  end

  always_comb begin
    i_next.t2 = h.t2;
    i_next.s  = 65'(h.sqx) + 65'(h.sqy);
  end

  snpo_sqrt #(
    .R_W  (33),
    .TAG_W($bits(t2_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .src_valid(i_v),
    .src_ready(sq_src_ready),
    .radicand (66'(i.s)),
    .src_tag  (i.t2),
    .dst_valid(sq_dst_valid),
    .dst_ready(rdy_j),
    .root     (vlen),
    .dst_tag  (sq_tag)
  );

  // Push numerators |v| * w2, split over the two halves of w2.
  always_comb begin
    j_next.t3.fx    = sq_t2.fx;
    j_next.t3.fy    = sq_t2.fy;
    j_next.t3.neg_x = sq_t2.neg_x;
    j_next.t3.neg_y = sq_t2.neg_y;
    j_next.t3.kind  = sq_t2.kind;
    j_next.t3.zero  = sq_t2.zero;
    j_next.vlen     = vlen;
    j_next.plx = PL_W'(sq_t2.avx) * PL_W'(w2[W2L-1:0]);
    j_next.ply = PL_W'(sq_t2.avy) * PL_W'(w2[W2L-1:0]);
    j_next.phx = PH_W'(sq_t2.avx) * PH_W'(w2[W2_W-1:W2L]);
    j_next.phy = PH_W'(sq_t2.avy) * PH_W'(w2[W2_W-1:W2L]);
  end

  always_comb begin
    k_next.t3   = j.t3;
    k_next.vlen = j.vlen;
    k_next.n2x  = (N2_W'(j.phx) << W2L) + N2_W'(j.plx);
    k_next.n2y  = (N2_W'(j.phy) << W2L) + N2_W'(j.ply);
  end

  snpo_div #(
    .N_W  (N2_W),
    .D_W  (33),
    .Q_W  (W2_W),
    .TAG_W($bits(t3_t))
  ) u_div_push (
    .clk      (clk),
    .rst      (rst),
    .src_valid(k_v),
    .src_ready(d2_src_ready),
    .num_a    (k.n2x),
    .num_b    (k.n2y),
    .divisor  (k.vlen),
    .src_tag  (k.t3),
    .dst_valid(d2_dst_valid),
    .dst_ready(rdy_l),
    .quo_a    (ox),
    .quo_b    (oy),
    .dst_tag  (d2_tag)
  );

  // Apply the push away from the query and saturate.
  always_comb begin
    logic signed [RS_W-1:0] bx, by, px, py, sumx, sumy;
    bx   = RS_W'(d2_t3.fx);
    by   = RS_W'(d2_t3.fy);
    px   = $signed(RS_W'(ox));
    py   = $signed(RS_W'(oy));
    sumx = d2_t3.neg_x ? bx - px : bx + px;
    sumy = d2_t3.neg_y ? by - py : by + py;
    l_next.result_x      = d2_t3.zero ? d2_t3.fx : $signed(sat(sumx));
    l_next.result_y      = d2_t3.zero ? d2_t3.fy : $signed(sat(sumy));
    l_next.clamp_case    = d2_t3.kind;
    l_next.zero_distance = d2_t3.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
      k_v <= 1'b0;
      l_v <= 1'b0;
    end else begin
      if (rdy_a) a_v <= query_valid;
      if (rdy_b) b_v <= a_v;
      if (rdy_c) c_v <= b_v;
      if (rdy_d) d_v <= c_v;
      if (rdy_e) e_v <= d_v;
      if (rdy_f) f_v <= d1_dst_valid;
      if (rdy_g) g_v <= f_v;
      if (rdy_h) h_v <= g_v;
      if (rdy_i) i_v <= h_v;
      if (rdy_j) j_v <= sq_dst_valid;
      if (rdy_k) k_v <= j_v;
      if (rdy_l) l_v <= d2_dst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) a <= a_next;
    if (rdy_b) b <= b_next;
    if (rdy_c) c <= c_next;
    if (rdy_d) d <= d_next;
    if (rdy_e) e <= e_next;
    if (rdy_f) f <= f_next;
    if (rdy_g) g <= g_next;
    if (rdy_h) h <= h_next;
    if (rdy_i) i <= i_next;
    if (rdy_j) j <= j_next;
    if (rdy_k) k <= k_next;
    if (rdy_l) result <= l_next;
  end

endmodule
